// File: sv/smi_pkg.sv
// Shared types and constants for the stack machine interpreter.
// No dependencies; every other file imports this package.
package smi_pkg;

    localparam logic [1:0] KIND_WCODE = 2'd0;
    localparam logic [1:0] KIND_WDATA = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_STEP  = 2'd3;

    localparam logic [1:0] CFG_MAIN_ENTRY = 2'd0;
    localparam logic [1:0] CFG_ARG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_ARG_VECTOR = 2'd2;
    localparam int CFG_DATA_W = 20;

    localparam logic [2:0] FAULT_NONE     = 3'd0;
    localparam logic [2:0] FAULT_OPCODE   = 3'd1;
    localparam logic [2:0] FAULT_DIV_ZERO = 3'd2;
    localparam logic [2:0] FAULT_NO_MAIN  = 3'd3;
    localparam logic [2:0] FAULT_RANGE    = 3'd4;

    localparam logic [63:0] RET_MARK = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]         kind;
        logic [16:0]        word_address;
        logic signed [63:0] word_value;
    } in_item_t;

    typedef struct packed {
        logic [16:0]        program_counter;
        logic signed [63:0] accumulator_value;
        logic               halted;
        logic signed [63:0] exit_value;
        logic [2:0]         fault_code;
        logic [47:0]        steps_done;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_WCODE,
        CMD_WDATA,
        CMD_START,
        CMD_STEP,
        CMD_DROP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [16:0] addr;
        logic [63:0] value;
    } cmd_t;

    typedef enum logic [5:0] {
        OP_IMM  = 6'd0,  OP_LEA  = 6'd1,  OP_LC   = 6'd2,  OP_LI   = 6'd3,
        OP_SC   = 6'd4,  OP_SI   = 6'd5,  OP_PUSH = 6'd6,  OP_JMP  = 6'd7,
        OP_JZ   = 6'd8,  OP_JNZ  = 6'd9,  OP_OR   = 6'd10, OP_XOR  = 6'd11,
        OP_AND  = 6'd12, OP_EQ   = 6'd13, OP_NE   = 6'd14, OP_LT   = 6'd15,
        OP_LE   = 6'd16, OP_GT   = 6'd17, OP_GE   = 6'd18, OP_SHL  = 6'd19,
        OP_SHR  = 6'd20, OP_ADD  = 6'd21, OP_SUB  = 6'd22, OP_MUL  = 6'd23,
        OP_DIV  = 6'd24, OP_MOD  = 6'd25, OP_CALL = 6'd26, OP_NVAR = 6'd27,
        OP_DARG = 6'd28, OP_RET  = 6'd29, OP_EXIT = 6'd38, OP_BAD  = 6'd63
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FETCH,
        ST_OPCODE,
        ST_OPERAND,
        ST_EXEC,
        ST_RD_LO,
        ST_RD_HI,
        ST_RD_END,
        ST_EXEC2,
        ST_WR_LO,
        ST_WR_HI,
        ST_MUL,
        ST_DIV,
        ST_COMMIT,
        ST_REPORT
    } state_t;

    function automatic opcode_t decode_op(input logic [63:0] w);
        opcode_t r;
        if (w <= 64'd29 || w == 64'd38)
            r = opcode_t'(w[5:0]);
        else
            r = OP_BAD;
        return r;
    endfunction

    function automatic logic needs_operand(input opcode_t op);
        return op == OP_IMM || op == OP_LEA || op == OP_JMP || op == OP_JZ ||
               op == OP_JNZ || op == OP_CALL || op == OP_NVAR || op == OP_DARG;
    endfunction

    function automatic logic is_binary(input opcode_t op);
        return op >= OP_OR && op <= OP_MOD;
    endfunction

endpackage

// File: sv/smi_front.sv
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on smi_pkg.
module smi_front #(
    parameter int CODE_WORDS = 131072,
    parameter int DATA_WORDS = 131072
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  smi_pkg::in_item_t in_data,
    output logic             q_valid,
    output smi_pkg::cmd_t    q_cmd,
    input  logic             q_pop
);
    import smi_pkg::*;

    localparam logic [1:0] QFULL = 2'd2;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls;
    logic       push;

    // classify: writes beyond the store become drops
    always_comb
    begin
        cls.addr  = in_data.word_address;
        cls.value = in_data.word_value;
        unique case (in_data.kind)
            KIND_WCODE: cls.kind = (32'(in_data.word_address) < 32'(CODE_WORDS)) ?
                                   CMD_WCODE : CMD_DROP;
            KIND_WDATA: cls.kind = (32'(in_data.word_address) < 32'(DATA_WORDS)) ?
                                   CMD_WDATA : CMD_DROP;
            KIND_START: cls.kind = CMD_START;
            KIND_STEP:  cls.kind = CMD_STEP;
        endcase
    end

    assign in_ready = count_reg != QFULL;
    assign push     = in_valid && in_ready;
    assign q_valid  = count_reg != 2'd0;
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls;
    end

endmodule

// File: sv/smi_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on smi_pkg only by convention; standalone arithmetic unit.
module smi_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);
    import smi_pkg::*;

    localparam int STEPS = 64;
    localparam int CNTW  = $clog2(STEPS);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [63:0]     rem_reg, rem_next;
    logic [63:0]     quo_reg, quo_next;
    logic [63:0]     dvs_reg, dvs_next;
    logic [64:0]     rem_sh;
    logic [64:0]     diff;

    assign rem_sh = {rem_reg, quo_reg[63]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_next = diff[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/smi_back.sv
// Back end: sequencer that executes queued commands against the code store,
// the byte-addressed data memory and the machine registers. Uses smi_pkg, smi_div.
module smi_back #(
    parameter int CODE_WORDS = 131072,
    parameter int DATA_WORDS = 131072
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  smi_pkg::cmd_t       q_cmd,
    output logic                q_pop,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [19:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output smi_pkg::out_item_t  out_data
);
    import smi_pkg::*;

    localparam int CAW = $clog2(CODE_WORDS);
    localparam int DAW = $clog2(DATA_WORDS);
    localparam int PCW = (CAW + 1 > 17) ? CAW + 1 : 17;
    localparam logic [63:0] DATA_BYTES = 64'(DATA_WORDS) * 64'd8;
    localparam logic [63:0] WORD_LAST  = DATA_BYTES - 64'd8;
    localparam logic [63:0] CODE_LIM   = 64'(CODE_WORDS);

    // memories
    logic [63:0] code_mem [CODE_WORDS];
    logic [63:0] data_mem [DATA_WORDS];
    logic        cm_we, dm_we;
    logic [CAW-1:0] cm_idx;
    logic [DAW-1:0] dm_idx;
    logic [63:0] cm_wdata, dm_wdata, cm_rdata_reg, dm_rdata_reg;
    logic [7:0]  dm_be;

    always_ff @(posedge clk)
    begin
        if (cm_we)
            code_mem[cm_idx] <= cm_wdata;
        cm_rdata_reg <= code_mem[cm_idx];
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (dm_be[i])
                    data_mem[dm_idx][i*8 +: 8] <= dm_wdata[i*8 +: 8];
            end
        end
        dm_rdata_reg <= data_mem[dm_idx];
    end

    // control and architectural state
    state_t      state_reg, state_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic [63:0] ax_reg, ax_next, sp_reg, sp_next, bp_reg, bp_next;
    logic [63:0] exit_reg, exit_next;
    logic [47:0] steps_reg, steps_next;
    logic        halt_reg, halt_next;
    logic [2:0]  fault_reg, fault_next;
    logic [16:0] main_reg, main_next;
    logic [15:0] argc_reg, argc_next;
    logic [19:0] argv_reg, argv_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        ret_ph_reg, ret_ph_next;

    // datapath temporaries
    opcode_t     op_reg, op_next;
    logic [63:0] opnd_reg, opnd_next;
    logic [PCW-1:0] np_reg, np_next;
    logic [63:0] wsp_reg, wsp_next, wbp_reg, wbp_next, wax_reg, wax_next;
    logic [63:0] rval_reg, rval_next, lo_reg, lo_next;
    logic [63:0] rd_addr_reg, rd_addr_next, wr_addr_reg, wr_addr_next;
    logic [63:0] wr_val_reg, wr_val_next, ret_a_reg, ret_a_next;
    logic        rd_word_reg, rd_word_next, wr_word_reg, wr_word_next;
    logic [63:0] mul_acc_reg, mul_acc_next;
    logic        neg_q_reg, neg_q_next, neg_r_reg, neg_r_next;
    out_item_t   out_reg, out_next;

    // helpers
    logic [127:0] wr_sh;
    logic [15:0]  wr_be;
    logic [127:0] rd_cat_one, rd_cat_two;
    logic         rd_two;
    logic [63:0]  sp_m8, mul_x, mul_y, mul_p;
    logic         div_start, div_done;
    logic [63:0]  div_a, div_b, div_q, div_r;
    opcode_t      dec_op;
    logic         taken;

    function automatic logic word_ok(input logic [63:0] a);
        return a <= WORD_LAST;
    endfunction

    function automatic logic [63:0] sext8(input logic [7:0] b);
        return {{56{b[7]}}, b};
    endfunction

    function automatic logic [63:0] alu(input opcode_t op, input logic [63:0] a,
                                        input logic [63:0] b);
        logic [63:0] r;
        unique case (op)
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_AND:  r = a & b;
            OP_EQ:   r = {63'd0, a == b};
            OP_NE:   r = {63'd0, a != b};
            OP_LT:   r = {63'd0, $signed(a) < $signed(b)};
            OP_LE:   r = {63'd0, $signed(a) <= $signed(b)};
            OP_GT:   r = {63'd0, $signed(a) > $signed(b)};
            OP_GE:   r = {63'd0, $signed(a) >= $signed(b)};
            OP_SHL:  r = a << b[5:0];
            OP_SHR:  r = 64'($signed(a) >>> b[5:0]);
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign wr_sh      = {64'd0, wr_val_reg} << {wr_addr_reg[2:0], 3'b000};
    assign wr_be      = {8'd0, (wr_word_reg ? 8'hFF : 8'h01)} << wr_addr_reg[2:0];
    assign rd_two     = rd_word_reg && (rd_addr_reg[2:0] != 3'd0);
    assign rd_cat_one = {dm_rdata_reg, dm_rdata_reg} >> {rd_addr_reg[2:0], 3'b000};
    assign rd_cat_two = {dm_rdata_reg, lo_reg} >> {rd_addr_reg[2:0], 3'b000};
    assign sp_m8      = sp_reg - 64'd8;
    assign dec_op     = decode_op(cm_rdata_reg);
    assign taken      = op_reg == OP_JMP || (op_reg == OP_JZ && ax_reg == 64'd0) ||
                        (op_reg == OP_JNZ && ax_reg != 64'd0);

    // low 64 bits of a*b from three 32x32 partial products
    assign mul_x = {32'd0, (cnt_reg == 2'd2) ? rval_reg[63:32] : rval_reg[31:0]};
    assign mul_y = {32'd0, (cnt_reg == 2'd1) ? ax_reg[63:32] : ax_reg[31:0]};
    assign mul_p = mul_x[31:0] * mul_y[31:0];

    assign div_a = rval_reg[63] ? (64'd0 - rval_reg) : rval_reg;
    assign div_b = ax_reg[63] ? (64'd0 - ax_reg) : ax_reg;

    smi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign q_pop = (state_reg == ST_IDLE) && q_valid && !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        ax_next        = ax_reg;
        sp_next        = sp_reg;
        bp_next        = bp_reg;
        exit_next      = exit_reg;
        steps_next     = steps_reg;
        halt_next      = halt_reg;
        fault_next     = fault_reg;
        main_next      = main_reg;
        argc_next      = argc_reg;
        argv_next      = argv_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        ret_ph_next    = ret_ph_reg;
        op_next        = op_reg;
        opnd_next      = opnd_reg;
        np_next        = np_reg;
        wsp_next       = wsp_reg;
        wbp_next       = wbp_reg;
        wax_next       = wax_reg;
        rval_next      = rval_reg;
        lo_next        = lo_reg;
        rd_addr_next   = rd_addr_reg;
        rd_word_next   = rd_word_reg;
        wr_addr_next   = wr_addr_reg;
        wr_val_next    = wr_val_reg;
        wr_word_next   = wr_word_reg;
        ret_a_next     = ret_a_reg;
        mul_acc_next   = mul_acc_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;
        out_next       = out_reg;
        cm_we          = 1'b0;
        cm_idx         = pc_reg[CAW-1:0];
        cm_wdata       = q_cmd.value;
        dm_we          = 1'b0;
        dm_idx         = rd_addr_reg[DAW+2:3];
        dm_wdata       = q_cmd.value;
        dm_be          = 8'hFF;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MAIN_ENTRY: main_next = cfg_data[16:0];
                CFG_ARG_COUNT:  argc_next = cfg_data[15:0];
                CFG_ARG_VECTOR: argv_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_cmd.kind)
                        CMD_WCODE:
                        begin
                            cm_we      = 1'b1;
                            cm_idx     = CAW'(q_cmd.addr);
                            state_next = ST_REPORT;
                        end
                        CMD_WDATA:
                        begin
                            dm_we      = 1'b1;
                            dm_idx     = DAW'(q_cmd.addr);
                            state_next = ST_REPORT;
                        end
                        CMD_START:
                        begin
                            cnt_next   = 2'd0;
                            state_next = ST_START;
                        end
                        CMD_STEP:  state_next = ST_FETCH;
                        default:   state_next = ST_REPORT;
                    endcase
                end
            end

            // push argc, argv and the return marker at the top of memory
            ST_START:
            begin
                dm_we  = 1'b1;
                dm_idx = DAW'(DATA_WORDS - 1) - DAW'(cnt_reg);
                unique case (cnt_reg)
                    2'd0:    dm_wdata = {48'd0, argc_reg};
                    2'd1:    dm_wdata = {44'd0, argv_reg};
                    default: dm_wdata = RET_MARK;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    bp_next    = DATA_BYTES;
                    sp_next    = DATA_BYTES - 64'd24;
                    ax_next    = '0;
                    steps_next = '0;
                    exit_next  = '0;
                    halt_next  = 1'b0;
                    fault_next = FAULT_NONE;
                    pc_next    = PCW'(main_reg);
                    if (main_reg == 17'd0)
                    begin
                        halt_next  = 1'b1;
                        fault_next = FAULT_NO_MAIN;
                    end
                    else if (32'(main_reg) >= 32'(CODE_WORDS))
                    begin
                        halt_next  = 1'b1;
                        fault_next = FAULT_RANGE;
                    end
                    state_next = ST_REPORT;
                end
            end

            ST_FETCH:
            begin
                if (halt_reg)
                    state_next = ST_REPORT;
                else
                begin
                    if (steps_reg != '1)
                        steps_next = steps_reg + 48'd1;
                    if (64'(pc_reg) >= CODE_LIM)
                    begin
                        halt_next  = 1'b1;
                        fault_next = FAULT_RANGE;
                        state_next = ST_REPORT;
                    end
                    else
                        state_next = ST_OPCODE;
                end
            end

            ST_OPCODE:
            begin
                op_next = dec_op;
                np_next = pc_reg + PCW'(1);
                cm_idx  = CAW'(pc_reg + PCW'(1));
                if (needs_operand(dec_op))
                begin
                    if (64'(pc_reg + PCW'(1)) >= CODE_LIM)
                    begin
                        halt_next  = 1'b1;
                        fault_next = FAULT_RANGE;
                        state_next = ST_REPORT;
                    end
                    else
                        state_next = ST_OPERAND;
                end
                else
                    state_next = ST_EXEC;
            end

            ST_OPERAND:
            begin
                opnd_next  = cm_rdata_reg;
                np_next    = np_reg + PCW'(1);
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                wsp_next = sp_reg;
                wbp_next = bp_reg;
                wax_next = ax_reg;
                state_next = ST_COMMIT;
                if (is_binary(op_reg) || op_reg == OP_SC || op_reg == OP_SI ||
                    op_reg == OP_EXIT)
                begin
                    rd_addr_next = sp_reg;
                    rd_word_next = 1'b1;
                    state_next   = word_ok(sp_reg) ? ST_RD_LO : ST_REPORT;
                end
                else
                begin
                    unique case (op_reg)
                        OP_IMM: wax_next = opnd_reg;
                        OP_LEA: wax_next = bp_reg + {opnd_reg[60:0], 3'b000};
                        OP_LC:
                        begin
                            rd_addr_next = ax_reg;
                            rd_word_next = 1'b0;
                            state_next   = (ax_reg < DATA_BYTES) ? ST_RD_LO : ST_REPORT;
                        end
                        OP_LI:
                        begin
                            rd_addr_next = ax_reg;
                            rd_word_next = 1'b1;
                            state_next   = word_ok(ax_reg) ? ST_RD_LO : ST_REPORT;
                        end
                        OP_PUSH:
                        begin
                            wr_addr_next = sp_m8;
                            wr_val_next  = ax_reg;
                            wr_word_next = 1'b1;
                            wsp_next     = sp_m8;
                            state_next   = word_ok(sp_m8) ? ST_WR_LO : ST_REPORT;
                        end
                        OP_JMP, OP_JZ, OP_JNZ:
                        begin
                            if (taken)
                            begin
                                np_next = PCW'(opnd_reg);
                                if (opnd_reg >= CODE_LIM)
                                    state_next = ST_REPORT;
                            end
                        end
                        OP_CALL:
                        begin
                            wr_addr_next = sp_m8;
                            wr_val_next  = 64'(np_reg);
                            wr_word_next = 1'b1;
                            wsp_next     = sp_m8;
                            np_next      = PCW'(opnd_reg);
                            state_next   = (opnd_reg < CODE_LIM && word_ok(sp_m8)) ?
                                           ST_WR_LO : ST_REPORT;
                        end
                        OP_NVAR:
                        begin
                            wr_addr_next = sp_m8;
                            wr_val_next  = bp_reg;
                            wr_word_next = 1'b1;
                            wbp_next     = sp_m8;
                            wsp_next     = sp_m8 - {opnd_reg[60:0], 3'b000};
                            state_next   = word_ok(sp_m8) ? ST_WR_LO : ST_REPORT;
                        end
                        OP_DARG: wsp_next = sp_reg + {opnd_reg[60:0], 3'b000};
                        OP_RET:
                        begin
                            rd_addr_next = bp_reg;
                            rd_word_next = 1'b1;
                            ret_ph_next  = 1'b0;
                            state_next   = (word_ok(bp_reg) && word_ok(bp_reg + 64'd8)) ?
                                           ST_RD_LO : ST_REPORT;
                        end
                        default:
                        begin
                            halt_next  = 1'b1;
                            fault_next = FAULT_OPCODE;
                            state_next = ST_REPORT;
                        end
                    endcase
                end
                // every path that lands in report from here, but for a bad opcode, is a range fault
                if (state_next == ST_REPORT && op_reg != OP_BAD)
                begin
                    halt_next  = 1'b1;
                    fault_next = FAULT_RANGE;
                end
            end

            ST_RD_LO:
            begin
                dm_idx     = rd_addr_reg[DAW+2:3];
                state_next = ST_RD_HI;
            end

            ST_RD_HI:
            begin
                lo_next = dm_rdata_reg;
                dm_idx  = rd_addr_reg[DAW+2:3] + DAW'(1);
                if (rd_two)
                    state_next = ST_RD_END;
                else
                begin
                    rval_next  = rd_cat_one[63:0];
                    state_next = ST_EXEC2;
                end
            end

            ST_RD_END:
            begin
                rval_next  = rd_cat_two[63:0];
                state_next = ST_EXEC2;
            end

            ST_EXEC2:
            begin
                state_next = ST_COMMIT;
                if (is_binary(op_reg))
                begin
                    wsp_next = sp_reg + 64'd8;
                    if (op_reg == OP_DIV || op_reg == OP_MOD)
                    begin
                        if (ax_reg == 64'd0)
                        begin
                            halt_next  = 1'b1;
                            fault_next = FAULT_DIV_ZERO;
                            state_next = ST_REPORT;
                        end
                        else
                        begin
                            neg_q_next = rval_reg[63] ^ ax_reg[63];
                            neg_r_next = rval_reg[63];
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    else if (op_reg == OP_MUL)
                    begin
                        cnt_next   = 2'd0;
                        state_next = ST_MUL;
                    end
                    else
                        wax_next = alu(op_reg, rval_reg, ax_reg);
                end
                else
                begin
                    unique case (op_reg)
                        OP_LC: wax_next = sext8(rval_reg[7:0]);
                        OP_LI: wax_next = rval_reg;
                        OP_SC:
                        begin
                            wr_addr_next = rval_reg;
                            wr_val_next  = ax_reg;
                            wr_word_next = 1'b0;
                            wax_next     = sext8(ax_reg[7:0]);
                            wsp_next     = sp_reg + 64'd8;
                            state_next   = ST_WR_LO;
                            if (rval_reg >= DATA_BYTES)
                            begin
                                halt_next  = 1'b1;
                                fault_next = FAULT_RANGE;
                                state_next = ST_REPORT;
                            end
                        end
                        OP_SI:
                        begin
                            wr_addr_next = rval_reg;
                            wr_val_next  = ax_reg;
                            wr_word_next = 1'b1;
                            wsp_next     = sp_reg + 64'd8;
                            state_next   = ST_WR_LO;
                            if (!word_ok(rval_reg))
                            begin
                                halt_next  = 1'b1;
                                fault_next = FAULT_RANGE;
                                state_next = ST_REPORT;
                            end
                        end
                        OP_RET:
                        begin
                            if (!ret_ph_reg)
                            begin
                                ret_a_next   = rval_reg;
                                ret_ph_next  = 1'b1;
                                rd_addr_next = bp_reg + 64'd8;
                                state_next   = ST_RD_LO;
                            end
                            else
                            begin
                                wsp_next = bp_reg + 64'd16;
                                wbp_next = ret_a_reg;
                                if (rval_reg == RET_MARK)
                                begin
                                    exit_next = ax_reg;
                                    halt_next = 1'b1;
                                end
                                else if (rval_reg >= CODE_LIM)
                                begin
                                    halt_next  = 1'b1;
                                    fault_next = FAULT_RANGE;
                                    state_next = ST_REPORT;
                                end
                                else
                                    np_next = PCW'(rval_reg);
                            end
                        end
                        OP_EXIT:
                        begin
                            exit_next = rval_reg;
                            halt_next = 1'b1;
                        end
                        default: state_next = ST_COMMIT;
                    endcase
                end
            end

            ST_WR_LO:
            begin
                dm_we    = 1'b1;
                dm_idx   = wr_addr_reg[DAW+2:3];
                dm_wdata = wr_sh[63:0];
                dm_be    = wr_be[7:0];
                state_next = (wr_be[15:8] != 8'd0) ? ST_WR_HI : ST_COMMIT;
            end

            ST_WR_HI:
            begin
                dm_we      = 1'b1;
                dm_idx     = wr_addr_reg[DAW+2:3] + DAW'(1);
                dm_wdata   = wr_sh[127:64];
                dm_be      = wr_be[15:8];
                state_next = ST_COMMIT;
            end

            ST_MUL:
            begin
                cnt_next = cnt_reg + 2'd1;
                unique case (cnt_reg)
                    2'd0:    mul_acc_next = mul_p;
                    2'd1:    mul_acc_next = mul_acc_reg + {mul_p[31:0], 32'd0};
                    default:
                    begin
                        wax_next   = mul_acc_reg + {mul_p[31:0], 32'd0};
                        state_next = ST_COMMIT;
                    end
                endcase
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    if (op_reg == OP_DIV)
                        wax_next = neg_q_reg ? (64'd0 - div_q) : div_q;
                    else
                        wax_next = neg_r_reg ? (64'd0 - div_r) : div_r;
                    state_next = ST_COMMIT;
                end
            end

            ST_COMMIT:
            begin
                pc_next    = np_reg;
                sp_next    = wsp_reg;
                bp_next    = wbp_reg;
                ax_next    = wax_reg;
                state_next = ST_REPORT;
            end

            ST_REPORT:
            begin
                out_next.program_counter   = pc_reg[16:0];
                out_next.accumulator_value = ax_reg;
                out_next.halted            = halt_reg;
                out_next.exit_value        = exit_reg;
                out_next.fault_code        = fault_reg;
                out_next.steps_done        = steps_reg;
                out_valid_next             = 1'b1;
                state_next                 = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            ax_reg        <= '0;
            sp_reg        <= DATA_BYTES;
            bp_reg        <= DATA_BYTES;
            exit_reg      <= '0;
            steps_reg     <= '0;
            halt_reg      <= 1'b1;
            fault_reg     <= FAULT_NONE;
            main_reg      <= '0;
            argc_reg      <= '0;
            argv_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            ret_ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            ax_reg        <= ax_next;
            sp_reg        <= sp_next;
            bp_reg        <= bp_next;
            exit_reg      <= exit_next;
            steps_reg     <= steps_next;
            halt_reg      <= halt_next;
            fault_reg     <= fault_next;
            main_reg      <= main_next;
            argc_reg      <= argc_next;
            argv_reg      <= argv_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            ret_ph_reg    <= ret_ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        opnd_reg    <= opnd_next;
        np_reg      <= np_next;
        wsp_reg     <= wsp_next;
        wbp_reg     <= wbp_next;
        wax_reg     <= wax_next;
        rval_reg    <= rval_next;
        lo_reg      <= lo_next;
        rd_addr_reg <= rd_addr_next;
        rd_word_reg <= rd_word_next;
        wr_addr_reg <= wr_addr_next;
        wr_val_reg  <= wr_val_next;
        wr_word_reg <= wr_word_next;
        ret_a_reg   <= ret_a_next;
        mul_acc_reg <= mul_acc_next;
        neg_q_reg   <= neg_q_next;
        neg_r_reg   <= neg_r_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: sv/stack_machine_interpreter.sv
// Each item passes the queue, then the back-end sequencer; a step's length is set by its
// opcode, the single-port data memory (unaligned words take two accesses, RET reads two
// words) and the divider for DIV/MOD. A step on a halted machine only reports.
// Throughput: one item at a time in the back end; a two-entry queue keeps input open.
// Reset: machine halted, pc and accumulator zero, stack and frame at top of memory,
// configuration zero; memories keep contents. Front feeds back sequencer; uses smi_pkg.
module stack_machine_interpreter #(
    parameter int CODE_WORDS = 131072,
    parameter int DATA_WORDS = 131072
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  smi_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output smi_pkg::out_item_t  out_data,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [19:0]         cfg_data
);
    import smi_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    smi_front #(
        .CODE_WORDS (CODE_WORDS),
        .DATA_WORDS (DATA_WORDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    smi_back #(
        .CODE_WORDS (CODE_WORDS),
        .DATA_WORDS (DATA_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

// File: sv/smi_checker.sv
// Port-level checks for the stack machine interpreter, bound to the top level.
// Uses smi_pkg.
module smi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input smi_pkg::out_item_t out_data
);
    import smi_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.fault_code == FAULT_NONE || out_data.halted))
        else $error("fault reported without halt");

    a_fault_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.fault_code <= FAULT_RANGE))
        else $error("fault code out of range");

    a_running_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.halted |->
            (out_data.exit_value == 64'sd0 && out_data.fault_code == FAULT_NONE))
        else $error("running machine shows exit value or fault");

endmodule

bind stack_machine_interpreter smi_checker u_smi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
